// File: rtl/tecq_pkg.sv
`default_nettype none

package tecq_pkg;

  // default queue depth
  localparam int unsigned QueueDepthDefault = 16;

  // gesture code that the controller uses for a filtered report
  localparam logic [7:0] FilteredGesture = 8'hFF;

  // stream widths in whole bytes, and the occupancy field width
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 88;
  localparam int unsigned OccW     = 5;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgNoGesture = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOnePoint  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTwoPoint  = 2'd2;

  // item operations
  typedef enum logic [1:0] {
    OpCapture = 2'd0,
    OpPop     = 2'd1,
    OpClear   = 2'd2
  } op_e;

  // configuration registers
  typedef struct packed {
    logic [7:0] no_gesture_code;
    logic [7:0] one_point_code;
    logic [7:0] two_point_code;
  } cfg_t;

  // one queue entry
  typedef struct packed {
    logic [15:0] second_y;
    logic [15:0] second_x;
    logic [15:0] first_y;
    logic [15:0] first_x;
    logic [7:0]  touches;
    logic [7:0]  event_code;
  } entry_t;

  // queue commands, meaningful only while step is high
  typedef struct packed {
    logic step;
    logic push;
    logic pop;
    logic clear;
  } q_ctl_t;

  // queue status for the current command
  typedef struct packed {
    logic            pop_hit;
    logic            overwrite;
    logic [OccW-1:0] occ_next;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/tecq_classify.sv
`default_nettype none

module tecq_classify (
  input  wire logic [1:0]   op_i,
  input  wire logic [7:0]   pending_count_i,
  input  wire logic [7:0]   gesture_in_i,
  input  wire logic [7:0]   touches_in_i,
  input  wire tecq_pkg::cfg_t cfg_i,
  output logic              keep_o,
  output logic [7:0]        event_code_o
);
  import tecq_pkg::*;

  logic       gest_keep;
  logic [7:0] gest_code;

  // no-gesture test has priority over the filtered code
  always_comb begin
    gest_keep = 1'b0;
    gest_code = '0;
    priority if (gesture_in_i == cfg_i.no_gesture_code) begin
      if (touches_in_i == 8'd1) begin
        gest_keep = 1'b1;
        gest_code = cfg_i.one_point_code;
      end else if (touches_in_i == 8'd2) begin
        gest_keep = 1'b1;
        gest_code = cfg_i.two_point_code;
      end
    end else if (gesture_in_i == FilteredGesture) begin
      gest_keep = 1'b0;
    end else begin
      gest_keep = 1'b1;
      gest_code = gesture_in_i;
    end
  end

  // only a capture with pending data stores an event
  assign keep_o       = (op_i == OpCapture) && (pending_count_i != 8'd0) && gest_keep;
  assign event_code_o = gest_code;

endmodule

`default_nettype wire

// File: rtl/tecq_store.sv
`default_nettype none

module tecq_store #(
  parameter int unsigned QUEUE_DEPTH = tecq_pkg::QueueDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tecq_pkg::q_ctl_t ctl_i,
  input  wire tecq_pkg::entry_t wdata_i,
  output tecq_pkg::q_stat_t     stat_o,
  output tecq_pkg::entry_t      rdata_o
);
  import tecq_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;

  logic [PtrW-1:0] rp_q, rp_d, wp_q, wp_d, rp_inc, wp_inc;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full, pop_hit, overwrite;

  // pointer wrap at the queue depth
  assign rp_inc = (rp_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign wp_inc = (wp_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;

  assign full      = (cnt_q == CntW'(QUEUE_DEPTH));
  assign pop_hit   = ctl_i.pop && (cnt_q != '0);
  assign overwrite = ctl_i.push && full;

  // next pointer and count state
  always_comb begin
    rp_d  = rp_q;
    wp_d  = wp_q;
    cnt_d = cnt_q;
    if (ctl_i.clear) begin
      rp_d  = '0;
      wp_d  = '0;
      cnt_d = '0;
    end else if (ctl_i.push) begin
      wp_d = wp_inc;
      if (full) begin
        rp_d = rp_inc;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (pop_hit) begin
      rp_d  = rp_inc;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      cnt_q <= '0;
    end else if (ctl_i.step) begin
      rp_q  <= rp_d;
      wp_q  <= wp_d;
      cnt_q <= cnt_d;
    end
  end

  // entry memory, registered read of the oldest entry
  always_ff @(posedge clk_i) begin
    if (ctl_i.step && ctl_i.push) begin
      mem[wp_q] <= wdata_i;
    end
    if (ctl_i.step) begin
      rd_q <= pop_hit ? mem[rp_q] : '0;
    end
  end

  assign stat_o.pop_hit   = pop_hit;
  assign stat_o.overwrite = overwrite;
  assign stat_o.occ_next  = OccW'(cnt_d);
  assign rdata_o          = rd_q;

  // count never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // empty or full queue has both pointers on the same slot
  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(QUEUE_DEPTH)) |-> wp_q == rp_q)
    else $error("pointers disagree with count");

  // a clear empties the queue
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step && ctl_i.clear) |=> cnt_q == '0)
    else $error("clear left entries");

  // an overwrite keeps the queue full
  a_ovw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step && overwrite) |=> cnt_q == CntW'(QUEUE_DEPTH))
    else $error("overwrite changed the count");

endmodule

`default_nettype wire

// File: rtl/touch_event_classify_queue.sv
`default_nettype none

// channel  | dir | fields
// ---------+-----+--------------------------------------------------------------
// s_axis   | in  | tuser: op; tdata: pending_count, gesture_in, touches_in,
//          |     |   first_x_in, first_y_in, second_x_in, second_y_in
// m_axis   | out | tdata: pop_valid, event_code, touches_out, first_x_out,
//          |     |   first_y_out, second_x_out, second_y_out, accepted,
//          |     |   overwrote_oldest, occupancy
// cfg      | in  | write enable, register index, 8-bit data
//
// one item per cycle while the result is not stalled; a taken item goes through the
// input register, then one pass through classifier and queue into the result register
// the queue is a register-file memory with one write and one registered read per cycle
// reset clears pointers, count, valids and sets the codes to 0, 1, 2; entries stay unset
// a stalled result holds; the input register still takes one more item, then ready drops

module touch_event_classify_queue #(
  parameter int unsigned QUEUE_DEPTH = tecq_pkg::QueueDepthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // slave side
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // pending_count, gesture_in, touches_in, first_x_in, first_y_in, second_x_in, second_y_in
  input  wire logic [tecq_pkg::InDataW-1:0]      s_axis_tdata_i,
  // op
  input  wire logic [1:0]                        s_axis_tuser_i,
  // master side
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // pop_valid, event_code, touches_out, first_x_out, first_y_out, second_x_out,
  // second_y_out, accepted, overwrote_oldest, occupancy
  output logic [tecq_pkg::OutDataW-1:0]          m_axis_tdata_o,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [tecq_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [7:0]                        cfg_wdata_i
);
  import tecq_pkg::*;

  cfg_t                cfg_q;
  logic                in_valid_q, out_valid_q, advance;
  logic [1:0]          in_op_q;
  logic [InDataW-1:0]  in_data_q;
  logic                keep;
  logic [7:0]          code;
  entry_t              wdata, rdata;
  q_ctl_t              ctl;
  q_stat_t             stat;
  logic                pop_valid_q, acc_q, ovw_q;
  logic [OccW-1:0]     occ_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.no_gesture_code <= 8'd0;
      cfg_q.one_point_code  <= 8'd1;
      cfg_q.two_point_code  <= 8'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNoGesture: cfg_q.no_gesture_code <= cfg_wdata_i;
        CfgOnePoint:  cfg_q.one_point_code  <= cfg_wdata_i;
        CfgTwoPoint:  cfg_q.two_point_code  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_op_q   <= s_axis_tuser_i;
      in_data_q <= s_axis_tdata_i;
    end
  end

  // event classification
  tecq_classify u_classify (
    .op_i            (in_op_q),
    .pending_count_i (in_data_q[7:0]),
    .gesture_in_i    (in_data_q[15:8]),
    .touches_in_i    (in_data_q[23:16]),
    .cfg_i           (cfg_q),
    .keep_o          (keep),
    .event_code_o    (code)
  );

  assign wdata.event_code = code;
  assign wdata.touches    = in_data_q[23:16];
  assign wdata.first_x    = in_data_q[39:24];
  assign wdata.first_y    = in_data_q[55:40];
  assign wdata.second_x   = in_data_q[71:56];
  assign wdata.second_y   = in_data_q[87:72];

  // queue commands for the item in the input register
  assign ctl.step  = advance;
  assign ctl.push  = keep;
  assign ctl.pop   = (in_op_q == OpPop);
  assign ctl.clear = (in_op_q == OpClear);

  tecq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .wdata_i (wdata),
    .stat_o  (stat),
    .rdata_o (rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pop_valid_q <= stat.pop_hit;
      acc_q       <= keep;
      ovw_q       <= stat.overwrite;
      occ_q       <= stat.occ_next;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {occ_q, ovw_q, acc_q, rdata.second_y, rdata.second_x,
                            rdata.first_y, rdata.first_x, rdata.touches,
                            rdata.event_code, pop_valid_q};

endmodule

`default_nettype wire
